### design/bmpfb_pkg.sv
// Package for the BMP pixel-array unpacker.
// Holds register indexes, field widths and the queue entry type.
// No dependencies.
package bmpfb_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FOUR_BYTE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 3'd4;

    localparam logic [11:0] RESET_IMAGE_WIDTH  = 12'd800;
    localparam logic [12:0] RESET_IMAGE_HEIGHT = 13'd480;

    localparam int ADDR_W      = 19;
    localparam int COLOR_W     = 32;
    localparam int ADDR_CALC_W = 25;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [11:0]        col;
        logic [11:0]        row;
        logic [COLOR_W-1:0] color;
    } t_pix_entry;

endpackage

### design/bmpfb_byte_if.sv
// Byte channel carrying the BMP pixel-array stream.
// No dependencies.
interface bmpfb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

### design/bmpfb_pix_if.sv
// Pixel channel carrying framebuffer address and ARGB color.
// Depends on bmpfb_pkg.
interface bmpfb_pix_if;
    logic                          valid;
    logic                          ready;
    logic [bmpfb_pkg::ADDR_W-1:0]  pixel_address;
    logic [bmpfb_pkg::COLOR_W-1:0] pixel_color;

    modport source (output valid, output pixel_address, output pixel_color, input ready);
    modport sink   (input valid, input pixel_address, input pixel_color, output ready);
endinterface

### design/bmpfb_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on bmpfb_pkg.
interface bmpfb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bmpfb_pkg::CFG_INDEX_W-1:0] index;
    logic [bmpfb_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/bmpfb_front.sv
// Front end: configuration registers, byte gathering, padding skip, row/column
// counting and screen clipping. Pushes on-screen pixels to the queue.
// Depends on bmpfb_pkg.
module bmpfb_front #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bmpfb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bmpfb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_byte_we,
    input  logic [7:0]                        i_byte,
    output logic                              o_push,
    output bmpfb_pkg::t_pix_entry             o_entry
);

    localparam logic [12:0] SW_LIM = 13'(SCREEN_WIDTH);
    localparam logic [12:0] SH_LIM = 13'(SCREEN_HEIGHT);

    function automatic logic [11:0] rows_total(input logic [12:0] h);
        logic [12:0] mag;
        mag = h[12] ? (~h + 13'd1) : h;
        return mag[12] ? 12'hFFF : mag[11:0];
    endfunction

    logic [11:0] r_width,  n_width;
    logic [12:0] r_height, n_height;
    logic        r_four,   n_four;
    logic [12:0] r_org_x,  n_org_x;
    logic [12:0] r_org_y,  n_org_y;
    logic [1:0]  r_phase,  n_phase;
    logic [23:0] r_bgr,    n_bgr;
    logic [11:0] r_col,    n_col;
    logic [11:0] r_row,    n_row;
    logic [1:0]  r_pad,    n_pad;
    logic        r_done,   n_done;

    logic [11:0]        rows;
    logic [11:0]        col_inc;
    logic [11:0]        row_inc;
    logic [1:0]         last_phase;
    logic signed [13:0] pos_x;
    logic signed [13:0] pos_y;
    logic signed [12:0] row_flip;
    logic               on_screen;
    logic [7:0]         alpha;

    assign rows       = rows_total(r_height);
    assign col_inc    = r_col + 12'd1;
    assign row_inc    = r_row + 12'd1;
    assign last_phase = r_four ? 2'd3 : 2'd2;
    assign row_flip   = r_height[12] ? $signed({1'b0, r_row})
                                     : $signed({1'b0, rows}) - $signed({1'b0, r_row})
                                       - 13'sd1;
    assign pos_x      = $signed({2'b00, r_col}) + $signed({r_org_x[12], r_org_x});
    assign pos_y      = $signed({row_flip[12], row_flip}) + $signed({r_org_y[12], r_org_y});
    assign on_screen  = !pos_x[13] && (pos_x[12:0] < SW_LIM)
                     && !pos_y[13] && (pos_y[12:0] < SH_LIM);
    assign alpha      = r_four ? i_byte : 8'h00;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_four   = r_four;
        n_org_x  = r_org_x;
        n_org_y  = r_org_y;
        n_phase  = r_phase;
        n_bgr    = r_bgr;
        n_col    = r_col;
        n_row    = r_row;
        n_pad    = r_pad;
        n_done   = r_done;
        o_push   = 1'b0;
        o_entry.col   = pos_x[11:0];
        o_entry.row   = pos_y[11:0];
        o_entry.color = r_four ? {i_byte, r_bgr} : {alpha, i_byte, r_bgr[15:0]};

        if (i_cfg_we && (i_cfg_index <= bmpfb_pkg::REG_ORIGIN_Y)) begin
            case (i_cfg_index)
                bmpfb_pkg::REG_IMAGE_WIDTH:  n_width  = i_cfg_data[11:0];
                bmpfb_pkg::REG_IMAGE_HEIGHT: n_height = i_cfg_data;
                bmpfb_pkg::REG_FOUR_BYTE:    n_four   = i_cfg_data[0];
                bmpfb_pkg::REG_ORIGIN_X:     n_org_x  = i_cfg_data;
                bmpfb_pkg::REG_ORIGIN_Y:     n_org_y  = i_cfg_data;
                default: ;
            endcase
            n_phase = 2'd0;
            n_bgr   = 24'd0;
            n_col   = 12'd0;
            n_row   = 12'd0;
            n_pad   = 2'd0;
            n_done  = (n_width == 12'd0) || (rows_total(n_height) == 12'd0);
        end else if (i_byte_we && !r_done) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
                if (r_pad == 2'd1) begin
                    n_col = 12'd0;
                    n_row = row_inc;
                    if (row_inc >= rows) begin
                        n_done = 1'b1;
                    end
                end
            end else if (r_phase < last_phase) begin
                case (r_phase)
                    2'd0:    n_bgr[7:0]   = i_byte;
                    2'd1:    n_bgr[15:8]  = i_byte;
                    default: n_bgr[23:16] = i_byte;
                endcase
                n_phase = r_phase + 2'd1;
            end else begin
                o_push  = on_screen;
                n_phase = 2'd0;
                n_bgr   = 24'd0;
                if (col_inc >= r_width) begin
                    if (r_four || (r_width[1:0] == 2'd0)) begin
                        n_col = 12'd0;
                        n_row = row_inc;
                        if (row_inc >= rows) begin
                            n_done = 1'b1;
                        end
                    end else begin
                        n_col = col_inc;
                        n_pad = r_width[1:0];
                    end
                end else begin
                    n_col = col_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bmpfb_pkg::RESET_IMAGE_WIDTH;
            r_height <= bmpfb_pkg::RESET_IMAGE_HEIGHT;
            r_four   <= 1'b0;
            r_org_x  <= 13'd0;
            r_org_y  <= 13'd0;
            r_phase  <= 2'd0;
            r_bgr    <= 24'd0;
            r_col    <= 12'd0;
            r_row    <= 12'd0;
            r_pad    <= 2'd0;
            r_done   <= 1'b0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_four   <= n_four;
            r_org_x  <= n_org_x;
            r_org_y  <= n_org_y;
            r_phase  <= n_phase;
            r_bgr    <= n_bgr;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pad    <= n_pad;
            r_done   <= n_done;
        end
    end

endmodule

### design/bmpfb_queue.sv
// Short FIFO of clipped pixels between the front and back ends.
// Depends on bmpfb_pkg.
module bmpfb_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bmpfb_pkg::t_pix_entry i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output bmpfb_pkg::t_pix_entry o_entry
);

    bmpfb_pkg::t_pix_entry r_mem [bmpfb_pkg::QUEUE_DEPTH];

    logic [bmpfb_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [bmpfb_pkg::QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [bmpfb_pkg::QUEUE_CNT_W-1:0] r_count,  n_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_full  = (r_count == bmpfb_pkg::QUEUE_CNT_W'(bmpfb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### design/bmpfb_back.sv
// Back end: turns queued pixels into framebuffer addresses and holds the
// result in the output register. Depends on bmpfb_pkg.
module bmpfb_back #(
    parameter int SCREEN_WIDTH = 800
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  bmpfb_pkg::t_pix_entry           i_entry,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bmpfb_pkg::ADDR_W-1:0]    o_addr,
    output logic [bmpfb_pkg::COLOR_W-1:0]   o_color
);

    localparam logic [bmpfb_pkg::ADDR_CALC_W-1:0] SW_MUL =
        bmpfb_pkg::ADDR_CALC_W'(SCREEN_WIDTH);

    logic                                r_valid, n_valid;
    logic [bmpfb_pkg::ADDR_W-1:0]        r_addr;
    logic [bmpfb_pkg::COLOR_W-1:0]       r_color;
    logic [bmpfb_pkg::ADDR_CALC_W-1:0]   full_addr;
    logic                                load;

    assign load      = !r_valid || i_ready;
    assign o_pop     = load && i_valid;
    assign full_addr = bmpfb_pkg::ADDR_CALC_W'(i_entry.row) * SW_MUL
                     + bmpfb_pkg::ADDR_CALC_W'(i_entry.col);
    assign n_valid   = load ? i_valid : r_valid;
    assign o_valid   = r_valid;
    assign o_addr    = r_addr;
    assign o_color   = r_color;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr  <= full_addr[bmpfb_pkg::ADDR_W-1:0];
            r_color <= i_entry.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

### design/bmp_pixel_stream_to_framebuffer.sv
// BMP pixel-array unpacker: one byte per cycle in, one ARGB pixel and its
// framebuffer word address out for each on-screen pixel. The byte channel takes a
// byte every cycle while the four-entry pixel queue has room; a pixel goes through
// the queue to the output register; results leave one per cycle while ready is high.
// Configuration writes are taken at once and restart the row and column counters.
module bmp_pixel_stream_to_framebuffer #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bmpfb_byte_if.sink         i_byte,
    bmpfb_pix_if.source        o_pix,
    bmpfb_cfg_if.sink          i_cfg
);

    logic                  front_push;
    bmpfb_pkg::t_pix_entry front_entry;
    logic                  queue_full;
    logic                  queue_valid;
    bmpfb_pkg::t_pix_entry queue_entry;
    logic                  back_pop;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = !queue_full;

    bmpfb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_byte_we   (i_byte.valid && !queue_full),
        .i_byte      (i_byte.pixel_byte),
        .o_push      (front_push),
        .o_entry     (front_entry)
    );

    bmpfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_entry (front_entry),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_entry (queue_entry)
    );

    bmpfb_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_entry (queue_entry),
        .o_pop   (back_pop),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_addr  (o_pix.pixel_address),
        .o_color (o_pix.pixel_color)
    );

endmodule
